// ===== sv/vcac_pkg.sv =====
// vcac_pkg: types and constants for the vertical capsule / box contact unit
// no dependencies; imported by vertical_capsule_aabb_contact_unit
`default_nettype none
package vcac_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 16;
    localparam int LATENCY    = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    localparam logic [15:0] EPS_RESET = 16'd1;
    localparam logic signed [17:0] N_POS  = 18'sd65536;
    localparam logic signed [17:0] N_NEG  = -18'sd65536;
    localparam logic signed [17:0] N_ZERO = 18'sd0;

    typedef enum logic [2:0] {
        FACE_LEFT   = 3'd0,
        FACE_RIGHT  = 3'd1,
        FACE_FRONT  = 3'd2,
        FACE_BACK   = 3'd3,
        FACE_BOTTOM = 3'd4,
        FACE_TOP    = 3'd5
    } face_t;

    // carried alongside the square root
    typedef struct packed {
        logic        miss;
        logic [2:0]  sgn;
        logic [30:0] ax;
        logic [30:0] ay;
        logic [30:0] az;
        logic [30:0] rad;
        face_t       face;
        logic [31:0] fdepth;
    } sq_side_t;

    // carried alongside the normal division
    typedef struct packed {
        logic        miss;
        logic        clear;
        logic [2:0]  sgn;
        logic [31:0] pen;
        face_t       face;
        logic [31:0] fdepth;
    } dv_side_t;

endpackage
`default_nettype wire

// ===== sv/vertical_capsule_aabb_contact_unit.sv =====
// vertical_capsule_aabb_contact_unit: pipelined capsule versus box contact test
// depends on vcac_pkg
//
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// item in   | start, busy        | base_*, tip_y, radius, box_min_*, box_max_*
// result    | done (one cycle)   | hit, normal_x/y/z, depth
// config    | cfg_we             | cfg_wdata (epsilon)
//
// one word enters per cycle; busy is always low
// a result is presented on done after its word passes the front stages, the 32-step
// square root and the normal division chained in the pipeline
// reset clears all stage valid bits and sets epsilon to 1
// the receiver cannot stall, so nothing holds the pipeline
`default_nettype none
module vertical_capsule_aabb_contact_unit
    import vcac_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic signed [31:0] base_x,
    input  wire logic signed [31:0] base_y,
    input  wire logic signed [31:0] base_z,
    input  wire logic signed [31:0] tip_y,
    input  wire logic [30:0]        radius,
    input  wire logic signed [31:0] box_min_x,
    input  wire logic signed [31:0] box_min_y,
    input  wire logic signed [31:0] box_min_z,
    input  wire logic signed [31:0] box_max_x,
    input  wire logic signed [31:0] box_max_y,
    input  wire logic signed [31:0] box_max_z,
    output logic                    done,
    output logic                    hit,
    output logic signed [17:0]      normal_x,
    output logic signed [17:0]      normal_y,
    output logic signed [17:0]      normal_z,
    output logic [31:0]             depth
);

    logic [15:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // stage 1: segment span and box clamps
    logic               v1_reg;
    logic signed [31:0] cx1_reg, cz1_reg, smin1_reg, smax1_reg;
    logic signed [31:0] bx1_reg, by1_reg, bz1_reg;
    logic signed [31:0] mnx1_reg, mny1_reg, mnz1_reg, mxx1_reg, mxy1_reg, mxz1_reg;
    logic [30:0]        r1_reg;
    logic signed [31:0] smin1_next, smax1_next, bx1_next, by1_next, bz1_next;

    always_comb
    begin
        smin1_next = (base_y < tip_y) ? base_y : tip_y;
        smax1_next = (base_y < tip_y) ? tip_y : base_y;
        bx1_next = (base_x < box_min_x) ? box_min_x :
                   ((base_x > box_max_x) ? box_max_x : base_x);
        bz1_next = (base_z < box_min_z) ? box_min_z :
                   ((base_z > box_max_z) ? box_max_z : base_z);
        by1_next = (smin1_next < box_min_y) ? box_min_y :
                   ((smin1_next > box_max_y) ? box_max_y : smin1_next);
    end

    always_ff @(posedge clk)
    begin
        cx1_reg   <= base_x;
        cz1_reg   <= base_z;
        smin1_reg <= smin1_next;
        smax1_reg <= smax1_next;
        bx1_reg   <= bx1_next;
        by1_reg   <= by1_next;
        bz1_reg   <= bz1_next;
        mnx1_reg  <= box_min_x;
        mny1_reg  <= box_min_y;
        mnz1_reg  <= box_min_z;
        mxx1_reg  <= box_max_x;
        mxy1_reg  <= box_max_y;
        mxz1_reg  <= box_max_z;
        r1_reg    <= radius;
    end

    // stage 2: differences and face distances
    logic               v2_reg;
    logic signed [32:0] dx2_reg, dy2_reg, dz2_reg;
    logic signed [32:0] fd2_reg [0:5];
    logic [30:0]        r2_reg;
    logic signed [31:0] sy2_next;

    function automatic logic signed [32:0] sx33(input logic signed [31:0] a);
        sx33 = {a[31], a};
    endfunction

    always_comb
    begin
        sy2_next = (by1_reg < smin1_reg) ? smin1_reg :
                   ((by1_reg > smax1_reg) ? smax1_reg : by1_reg);
    end

    always_ff @(posedge clk)
    begin
        dx2_reg    <= sx33(cx1_reg) - sx33(bx1_reg);
        dy2_reg    <= sx33(sy2_next) - sx33(by1_reg);
        dz2_reg    <= sx33(cz1_reg) - sx33(bz1_reg);
        fd2_reg[0] <= sx33(cx1_reg) - sx33(mnx1_reg);
        fd2_reg[1] <= sx33(mxx1_reg) - sx33(cx1_reg);
        fd2_reg[2] <= sx33(cz1_reg) - sx33(mnz1_reg);
        fd2_reg[3] <= sx33(mxz1_reg) - sx33(cz1_reg);
        fd2_reg[4] <= sx33(smax1_reg) - sx33(mny1_reg);
        fd2_reg[5] <= sx33(mxy1_reg) - sx33(smin1_reg);
        r2_reg     <= r1_reg;
    end

    // stage 3: magnitudes, far test, first face compare
    logic               v3_reg;
    logic [32:0]        ax3_reg, ay3_reg, az3_reg;
    logic [2:0]         sgn3_reg;
    logic               far3_reg;
    logic [30:0]        r3_reg;
    logic signed [32:0] fv3_reg [0:2];
    face_t              fc3_reg [0:2];
    logic [32:0]        ax3_next, ay3_next, az3_next;

    always_comb
    begin
        ax3_next = dx2_reg[32] ? 33'(-dx2_reg) : 33'(dx2_reg);
        ay3_next = dy2_reg[32] ? 33'(-dy2_reg) : 33'(dy2_reg);
        az3_next = dz2_reg[32] ? 33'(-dz2_reg) : 33'(dz2_reg);
    end

    always_ff @(posedge clk)
    begin
        ax3_reg  <= ax3_next;
        ay3_reg  <= ay3_next;
        az3_reg  <= az3_next;
        sgn3_reg <= {dz2_reg[32], dy2_reg[32], dx2_reg[32]};
        far3_reg <= (ax3_next > {2'b00, r2_reg}) || (ay3_next > {2'b00, r2_reg}) ||
                    (az3_next > {2'b00, r2_reg});
        r3_reg   <= r2_reg;
        fv3_reg[0] <= (fd2_reg[1] < fd2_reg[0]) ? fd2_reg[1] : fd2_reg[0];
        fc3_reg[0] <= (fd2_reg[1] < fd2_reg[0]) ? FACE_RIGHT : FACE_LEFT;
        fv3_reg[1] <= (fd2_reg[3] < fd2_reg[2]) ? fd2_reg[3] : fd2_reg[2];
        fc3_reg[1] <= (fd2_reg[3] < fd2_reg[2]) ? FACE_BACK : FACE_FRONT;
        fv3_reg[2] <= (fd2_reg[5] < fd2_reg[4]) ? fd2_reg[5] : fd2_reg[4];
        fc3_reg[2] <= (fd2_reg[5] < fd2_reg[4]) ? FACE_TOP : FACE_BOTTOM;
    end

    // stage 4: squares, final face pick
    logic               v4_reg;
    logic [61:0]        sqx4_reg, sqy4_reg, sqz4_reg, rr4_reg;
    logic [30:0]        ax4_reg, ay4_reg, az4_reg, r4_reg;
    logic [2:0]         sgn4_reg;
    logic               far4_reg;
    logic signed [32:0] fv4_reg;
    face_t              fc4_reg;
    logic signed [32:0] fva_next;
    face_t              fca_next;

    always_comb
    begin
        fva_next = (fv3_reg[1] < fv3_reg[0]) ? fv3_reg[1] : fv3_reg[0];
        fca_next = (fv3_reg[1] < fv3_reg[0]) ? fc3_reg[1] : fc3_reg[0];
    end

    always_ff @(posedge clk)
    begin
        sqx4_reg <= 62'(ax3_reg[30:0]) * 62'(ax3_reg[30:0]);
        sqy4_reg <= 62'(ay3_reg[30:0]) * 62'(ay3_reg[30:0]);
        sqz4_reg <= 62'(az3_reg[30:0]) * 62'(az3_reg[30:0]);
        rr4_reg  <= 62'(r3_reg) * 62'(r3_reg);
        ax4_reg  <= ax3_reg[30:0];
        ay4_reg  <= ay3_reg[30:0];
        az4_reg  <= az3_reg[30:0];
        r4_reg   <= r3_reg;
        sgn4_reg <= sgn3_reg;
        far4_reg <= far3_reg;
        fv4_reg  <= (fv3_reg[2] < fva_next) ? fv3_reg[2] : fva_next;
        fc4_reg  <= (fv3_reg[2] < fva_next) ? fc3_reg[2] : fca_next;
    end

    // stage 5: squared distance, miss test, face depth; feeds the square root
    logic [63:0]        sq_x_reg [0:SQRT_STEPS];
    logic [63:0]        sq_r_reg [0:SQRT_STEPS];
    sq_side_t           sq_side_reg [0:SQRT_STEPS];
    logic               sq_v_reg [0:SQRT_STEPS];
    logic [63:0]        dsq5_next;
    logic signed [34:0] p5_next;
    sq_side_t           side5_next;

    always_comb
    begin
        dsq5_next = 64'(sqx4_reg) + 64'(sqy4_reg) + 64'(sqz4_reg);
        p5_next   = 35'(signed'({4'b0000, r4_reg})) + 35'(fv4_reg);
        side5_next.miss = far4_reg || (dsq5_next > 64'(rr4_reg));
        side5_next.sgn  = sgn4_reg;
        side5_next.ax   = ax4_reg;
        side5_next.ay   = ay4_reg;
        side5_next.az   = az4_reg;
        side5_next.rad  = r4_reg;
        side5_next.face = fc4_reg;
        if (p5_next[34])
        begin
            side5_next.fdepth = 32'd0;
        end
        else if (p5_next[33:32] != 2'b00)
        begin
            side5_next.fdepth = 32'hFFFF_FFFF;
        end
        else
        begin
            side5_next.fdepth = p5_next[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg[0]    <= dsq5_next;
        sq_r_reg[0]    <= 64'd0;
        sq_side_reg[0] <= side5_next;
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] x_next, r_next, trial;

        always_comb
        begin
            trial = sq_r_reg[k] + BIT;
            if (sq_x_reg[k] >= trial)
            begin
                x_next = sq_x_reg[k] - trial;
                r_next = (sq_r_reg[k] >> 1) + BIT;
            end
            else
            begin
                x_next = sq_x_reg[k];
                r_next = sq_r_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_x_reg[k + 1]    <= x_next;
            sq_r_reg[k + 1]    <= r_next;
            sq_side_reg[k + 1] <= sq_side_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k + 1] <= 1'b0;
            end
            else
            begin
                sq_v_reg[k + 1] <= sq_v_reg[k];
            end
        end
    end

    // division setup: leading quotient bit, clear-hit decision, penetration
    logic [31:0] dv_rem_reg  [0:DIV_STEPS][0:2];
    logic [16:0] dv_q_reg    [0:DIV_STEPS][0:2];
    logic [31:0] dv_dist_reg [0:DIV_STEPS];
    dv_side_t    dv_side_reg [0:DIV_STEPS];
    logic        dv_v_reg    [0:DIV_STEPS];
    logic [31:0] dist0;
    logic [31:0] amag0 [0:2];
    sq_side_t    sqo;
    dv_side_t    dv0_next;

    always_comb
    begin
        sqo      = sq_side_reg[SQRT_STEPS];
        dist0    = sq_r_reg[SQRT_STEPS][31:0];
        amag0[0] = {1'b0, sqo.ax};
        amag0[1] = {1'b0, sqo.ay};
        amag0[2] = {1'b0, sqo.az};
        dv0_next.miss   = sqo.miss;
        dv0_next.clear  = dist0 > {16'd0, eps_reg};
        dv0_next.sgn    = sqo.sgn;
        dv0_next.pen    = {1'b0, sqo.rad} - dist0;
        dv0_next.face   = sqo.face;
        dv0_next.fdepth = sqo.fdepth;
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_div0
        always_ff @(posedge clk)
        begin
            dv_rem_reg[0][a] <= (amag0[a] == dist0) ? 32'd0 : amag0[a];
            dv_q_reg[0][a]   <= {16'd0, amag0[a] == dist0};
        end
    end

    always_ff @(posedge clk)
    begin
        dv_dist_reg[0] <= dist0;
        dv_side_reg[0] <= dv0_next;
    end

    // restoring division, one quotient bit per stage for each axis
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        for (genvar a = 0; a < 3; a++)
        begin : g_axis
            logic [32:0] rem2;
            logic        ge;

            always_comb
            begin
                rem2 = {dv_rem_reg[j][a], 1'b0};
                ge   = rem2 >= {1'b0, dv_dist_reg[j]};
            end

            always_ff @(posedge clk)
            begin
                dv_rem_reg[j + 1][a] <= ge ? 32'(rem2 - {1'b0, dv_dist_reg[j]})
                                           : rem2[31:0];
                dv_q_reg[j + 1][a]   <= {dv_q_reg[j][a][15:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            dv_dist_reg[j + 1] <= dv_dist_reg[j];
            dv_side_reg[j + 1] <= dv_side_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j + 1] <= 1'b0;
            end
            else
            begin
                dv_v_reg[j + 1] <= dv_v_reg[j];
            end
        end
    end

    // result selection
    logic                  done_reg, hit_reg;
    logic signed [17:0]    nx_reg, ny_reg, nz_reg;
    logic [31:0]           depth_reg;
    logic                  hit_next;
    logic signed [17:0]    nx_next, ny_next, nz_next;
    logic [31:0]           depth_next;
    logic signed [17:0]    nq [0:2];
    dv_side_t              dvo;

    always_comb
    begin
        dvo = dv_side_reg[DIV_STEPS];
        for (int a = 0; a < 3; a++)
        begin
            nq[a] = dvo.sgn[a] ? -signed'({1'b0, dv_q_reg[DIV_STEPS][a]})
                               : signed'({1'b0, dv_q_reg[DIV_STEPS][a]});
        end
        hit_next   = !dvo.miss;
        nx_next    = N_ZERO;
        ny_next    = N_ZERO;
        nz_next    = N_ZERO;
        depth_next = 32'd0;
        if (dvo.miss)
        begin
            hit_next = 1'b0;
        end
        else if (dvo.clear)
        begin
            nx_next    = nq[0];
            ny_next    = nq[1];
            nz_next    = nq[2];
            depth_next = dvo.pen;
        end
        else
        begin
            depth_next = dvo.fdepth;
            unique case (dvo.face)
                FACE_LEFT:   nx_next = N_NEG;
                FACE_RIGHT:  nx_next = N_POS;
                FACE_FRONT:  nz_next = N_NEG;
                FACE_BACK:   nz_next = N_POS;
                FACE_BOTTOM: ny_next = N_NEG;
                FACE_TOP:    ny_next = N_POS;
                default:     nx_next = N_ZERO;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        nz_reg    <= nz_next;
        depth_reg <= depth_next;
    end

    // valid bits of the front stages and the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
            dv_v_reg[0] <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            v1_reg      <= start && !busy;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            sq_v_reg[0] <= v4_reg;
            dv_v_reg[0] <= sq_v_reg[SQRT_STEPS];
            done_reg    <= dv_v_reg[DIV_STEPS];
        end
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign normal_x = nx_reg;
    assign normal_y = ny_reg;
    assign normal_z = nz_reg;
    assign depth    = depth_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##(LATENCY - 1) done)
        else $error("result word missing after fixed latency");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (normal_x == N_ZERO && normal_y == N_ZERO &&
                            normal_z == N_ZERO && depth == 32'd0))
        else $error("miss word carries nonzero payload");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (normal_x <= N_POS && normal_x >= N_NEG &&
                  normal_y <= N_POS && normal_y >= N_NEG &&
                  normal_z <= N_POS && normal_z >= N_NEG))
        else $error("normal component out of unit range");

endmodule
`default_nettype wire

// ===== tb/vertical_capsule_aabb_contact_unit_checker.sv =====
// checker for vertical_capsule_aabb_contact_unit: predicts each contact result and compares
// depends on vcac_pkg; instantiated by vertical_capsule_aabb_contact_unit_test
`timescale 1ns / 1ps
module vertical_capsule_aabb_contact_unit_checker
    import vcac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic signed [31:0] base_x,
    input  logic signed [31:0] base_y,
    input  logic signed [31:0] base_z,
    input  logic signed [31:0] tip_y,
    input  logic [30:0]        radius,
    input  logic signed [31:0] box_min_x,
    input  logic signed [31:0] box_min_y,
    input  logic signed [31:0] box_min_z,
    input  logic signed [31:0] box_max_x,
    input  logic signed [31:0] box_max_y,
    input  logic signed [31:0] box_max_z,
    input  logic               done,
    input  logic               hit,
    input  logic signed [17:0] normal_x,
    input  logic signed [17:0] normal_y,
    input  logic signed [17:0] normal_z,
    input  logic [31:0]        depth,
    output int                 errors,
    output int                 pending,
    output int                 results,
    output int                 hits
);

    typedef struct {
        logic               hit;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [17:0] nz;
        logic [31:0]        depth;
    } contact_t;

    contact_t    contact_q[$];
    logic [15:0] eps;

    function automatic longint clamp_axis(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [17:0] unit_comp(longint d, longint unsigned dlen);
        longint unsigned q;
        q = (abs64(d) << 16) / dlen;
        return 18'(d < 0 ? -q : q);
    endfunction

    function automatic contact_t predict_contact();
        contact_t c;
        longint cx, cz, y0, y1, smin, smax, mnx, mny, mnz, mxx, mxy, mxz;
        longint bx, by, bz, sy, dx, dy, dz, fd[6], p;
        longint unsigned r, ax, ay, az, dsq, dlen;
        int best;
        cx = base_x; cz = base_z; y0 = base_y; y1 = tip_y;
        r = radius;
        mnx = box_min_x; mny = box_min_y; mnz = box_min_z;
        mxx = box_max_x; mxy = box_max_y; mxz = box_max_z;
        smin = y0 < y1 ? y0 : y1;
        smax = y0 < y1 ? y1 : y0;
        bx = clamp_axis(cx, mnx, mxx);
        bz = clamp_axis(cz, mnz, mxz);
        by = clamp_axis(smin, mny, mxy);
        sy = clamp_axis(by, smin, smax);
        dx = cx - bx; dy = sy - by; dz = cz - bz;
        ax = abs64(dx); ay = abs64(dy); az = abs64(dz);
        c = '{1'b0, N_ZERO, N_ZERO, N_ZERO, 32'd0};
        if (ax > r || ay > r || az > r) return c;
        dsq = ax * ax + ay * ay + az * az;
        if (dsq > r * r) return c;
        dlen = root_floor(dsq);
        c.hit = 1'b1;
        if (dlen > eps)
        begin
            c.nx = unit_comp(dx, dlen);
            c.ny = unit_comp(dy, dlen);
            c.nz = unit_comp(dz, dlen);
            c.depth = 32'(r - dlen);
            return c;
        end
        fd[FACE_LEFT] = cx - mnx;
        fd[FACE_RIGHT] = mxx - cx;
        fd[FACE_FRONT] = cz - mnz;
        fd[FACE_BACK] = mxz - cz;
        fd[FACE_BOTTOM] = smax - mny;
        fd[FACE_TOP] = mxy - smin;
        best = FACE_LEFT;
        for (int i = 1; i < 6; i++)
            if (fd[i] < fd[best]) best = i;
        p = longint'(r) + fd[best];
        c.depth = p < 0 ? 32'd0 : (p > 64'sh0FFFFFFFF ? 32'hFFFFFFFF : p[31:0]);
        case (face_t'(best))
            FACE_LEFT:   c.nx = N_NEG;
            FACE_RIGHT:  c.nx = N_POS;
            FACE_FRONT:  c.nz = N_NEG;
            FACE_BACK:   c.nz = N_POS;
            FACE_BOTTOM: c.ny = N_NEG;
            default:     c.ny = N_POS;
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("result %0d: %s is %0d, expected %0d", results, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        results = 0;
        hits = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        contact_t w;
        if (!rst_n)
            eps <= EPS_RESET;
        else
        begin
            if (cfg_we)
                eps <= cfg_wdata;
            if (start && !busy)
                contact_q.push_back(predict_contact());
            if (done)
            begin
                if (contact_q.size() == 0)
                begin
                    report_mismatch("words waiting", 0, 1);
                end
                else
                begin
                    w = contact_q.pop_front();
                    if (hit !== w.hit) report_mismatch("hit", hit, w.hit);
                    if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, w.nx);
                    if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
                    if (normal_z !== w.nz) report_mismatch("normal_z", normal_z, w.nz);
                    if (depth !== w.depth) report_mismatch("depth", depth, w.depth);
                end
                if (hit === 1'b1) hits++;
                results++;
            end
            pending = contact_q.size();
        end
    end

endmodule

// ===== tb/vertical_capsule_aabb_contact_unit_test.sv =====
// stimulus and verdict for vertical_capsule_aabb_contact_unit
// depends on vcac_pkg and vertical_capsule_aabb_contact_unit_checker
`timescale 1ns / 1ps
module vertical_capsule_aabb_contact_unit_test;
    import vcac_pkg::*;

    localparam int LIMIT = 400000;

    logic clk, rst_n, start, busy, cfg_we, done, hit;
    logic [15:0] cfg_wdata;
    logic signed [31:0] base_x, base_y, base_z, tip_y;
    logic [30:0] radius;
    logic signed [31:0] box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z;
    logic signed [17:0] normal_x, normal_y, normal_z;
    logic [31:0] depth;
    int errors, pending, results, hits, words, cycles, idle_pct;

    vertical_capsule_aabb_contact_unit i_dut (.*);

    vertical_capsule_aabb_contact_unit_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("vertical_capsule_aabb_contact_unit: mismatch");
            $finish;
        end
    end

    task automatic send_word(input logic [31:0] bx, by, bz, ty, r,
                             input logic [31:0] nx, ny, nz, xx, xy, xz);
        base_x <= bx; base_y <= by; base_z <= bz; tip_y <= ty; radius <= r[30:0];
        box_min_x <= nx; box_min_y <= ny; box_min_z <= nz;
        box_max_x <= xx; box_max_y <= xy; box_max_z <= xz;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        words++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic set_epsilon(input logic [15:0] v);
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (LATENCY + 5) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_word();
        logic [31:0] c, s, sz, o[11];
        int kind;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            for (int i = 0; i < 11; i++) o[i] = $urandom;
        end
        else
        begin
            sz = 32'd1 << $urandom_range(22, 4);
            c = $urandom_range(2000) - 1000;
            c = c << 12;
            for (int i = 0; i < 3; i++)
            begin
                s = $urandom_range(sz);
                o[5 + i] = c - s;
                o[8 + i] = c + $urandom_range(sz);
                if (kind < 20) o[5 + i] = c + sz + 1;
            end
            o[0] = c + $urandom_range(4 * sz) - 2 * sz;
            o[2] = c + $urandom_range(4 * sz) - 2 * sz;
            o[1] = c + $urandom_range(4 * sz) - 2 * sz;
            o[3] = c + $urandom_range(4 * sz) - 2 * sz;
            if (kind < 40)
            begin
                o[0] = c;
                o[2] = c + $urandom_range(3);
            end
            o[4] = $urandom_range(2 * sz);
        end
        send_word(o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8], o[9], o[10]);
    endtask

    initial
    begin
        logic [31:0] mx, mn, t;
        cycles = 0;
        words = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        {base_x, base_y, base_z, tip_y, radius} = '0;
        {box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z} = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        mx = 32'h7FFFFFFF;
        mn = 32'h80000000;
        t = 32'd10 << 16;
        // extremes of all fields
        send_word(mx, mx, mx, mx, '1, mx, mx, mx, mx, mx, mx);
        send_word(mn, mn, mn, mn, '1, mn, mn, mn, mn, mn, mn);
        send_word(mn, mx, mn, mn, '1, mx, mn, mx, mn, mx, mn);
        send_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(mx, mn, mx, mx, '1, mn, mn, mn, mx, mx, mx);
        // clear miss and clear hit, segment given upside down
        send_word(t * 3, t, 0, -t, t, -t, -t, -t, t, t, t);
        send_word(t + 32'h8000, t, 0, -t, t, -t, -t, -t, t, t, t);
        send_word(t + 32'h4000, t * 2, t + 32'h4000, t + 32'h8000, t, -t, -t, -t, t, t, t);
        // degenerate: each face nearest, then an all-way tie
        send_word(-t + 1, 1, 0, -1, t, -t, -t, -t, t, t, t);
        send_word(t - 1, 1, 0, -1, t, -t, -t, -t, t, t, t);
        send_word(0, 1, -t + 1, -1, t, -t, -t, -t, t, t, t);
        send_word(0, 1, t - 1, -1, t, -t, -t, -t, t, t, t);
        send_word(0, -t + 1, 0, -t + 2, t, -t, -t, -t, t, t, t);
        send_word(0, t - 2, 0, t - 1, t, -t, -t, -t, t, t, t);
        send_word(0, 0, 0, 0, t, -t, -t, -t, t, t, t);
        // degenerate at the top corner of a full-range box, then a zero radius against an inverted box
        send_word(mx, mx, mx, mx, '1, mn, mn, mn, mx, mx, mx);
        send_word(0, 0, 0, 0, 0, t, t, t, -t, -t, -t);
        // inverted box
        send_word(0, 0, 0, t, t, t, t, t, -t, -t, -t);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: set_epsilon(16'd0);
                1: set_epsilon(16'hFFFF);
                2: set_epsilon(16'($urandom));
                default: set_epsilon(EPS_RESET);
            endcase
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 60;
                default: idle_pct = 6;
            endcase
            for (int i = 0; i < 212; i++) random_word();
        end
        start <= 1'b0;

        wait (pending == 0);
        repeat (LATENCY + 5) @(posedge clk);
        $display("%0d words sent, %0d results checked, %0d contacts", words, results, hits);
        $display("epsilon swept from 0 to 65535 under steady and gapped input");
        if (errors == 0)
            $display("vertical_capsule_aabb_contact_unit: match");
        else
            $display("vertical_capsule_aabb_contact_unit: mismatch");
        $finish;
    end

endmodule
